>>> src/gpr_pkg.sv
// Shared types, constants and glyph table for the glyph pixel renderer.
package gpr_pkg;

  localparam int GLYPH_ADVANCE = 4;
  localparam int FIRST_CODE    = 32;
  localparam int GLYPH_COUNT   = 96;
  localparam int CELL_PIXELS   = 15;
  localparam int COORD_W       = 16;
  localparam int COLOUR_W      = 8;
  localparam int CODE_W        = 8;
  localparam int GLYPH_IDX_W   = $clog2(GLYPH_COUNT);

  typedef logic [COORD_W-1:0]     coord_t;
  typedef logic [COLOUR_W-1:0]    colour_t;
  typedef logic [CELL_PIXELS-1:0] cell_mask_t;
  typedef logic [15:0]            glyph_entry_t;

  // Draw command handed from the front end to the cell scanner.
  typedef struct packed {
    cell_mask_t mask;
    coord_t     col;
    coord_t     row;
    colour_t    colour;
  } draw_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } scan_state_t;

  localparam glyph_entry_t GLYPH_ROM [GLYPH_COUNT] = '{
    16'h0000, 16'h4908, 16'hb400, 16'hbef6, 16'h7b7a, 16'ha594, 16'h55b8, 16'h4800,
    16'h2944, 16'h442a, 16'h15a0, 16'h0b42, 16'h0050, 16'h0302, 16'h0008, 16'h2590,
    16'h76ba, 16'h595c, 16'hc59e, 16'hc538, 16'h92e6, 16'hf33a, 16'h73ba, 16'he590,
    16'h77ba, 16'h773a, 16'h0840, 16'h0850, 16'h2a44, 16'h1ce0, 16'h8852, 16'he508,
    16'h568e, 16'h77b6, 16'h77b8, 16'h728c, 16'hd6ba, 16'h739e, 16'h7392, 16'h72ae,
    16'hb7b6, 16'he95c, 16'h64aa, 16'hb7b4, 16'h929c, 16'hbeb6, 16'hd6b6, 16'h56aa,
    16'hd792, 16'h76ee, 16'h77b4, 16'h7138, 16'he948, 16'hb6ae, 16'hb6aa, 16'hb6f6,
    16'hb5b4, 16'hb548, 16'he59c, 16'h694c, 16'h9124, 16'h642e, 16'h5400, 16'h001c,
    16'h4400, 16'h0eae, 16'h9aba, 16'h0e8c, 16'h2eae, 16'h0ece, 16'h56d0, 16'h553b,
    16'h93b4, 16'h4144, 16'h4151, 16'h97b4, 16'h4944, 16'h17b6, 16'h1ab6, 16'h0aaa,
    16'hd6d3, 16'h7667, 16'h1790, 16'h0f38, 16'h9a8c, 16'h16ae, 16'h16ba, 16'h16f6,
    16'h15b4, 16'hb52b, 16'h1c5e, 16'h6b4c, 16'h4948, 16'hc95a, 16'h5400, 16'h56e2
  };

  // Reorder entry bits into scan order: bit k is the k-th cell pixel,
  // row by row, left to right. Row 2 column 2 lives in entry bit 1.
  function automatic cell_mask_t scan_mask(glyph_entry_t entry);
    return {entry[2], entry[3], entry[4],
            entry[5], entry[6], entry[7],
            entry[1], entry[8], entry[9],
            entry[10], entry[11], entry[12],
            entry[13], entry[14], entry[15]};
  endfunction

endpackage

>>> src/gpr_cell_scan.sv
// Cell scanner: shifts the glyph mask out one bit per cycle unless stalled; emits pixel writes.
module gpr_cell_scan
  import gpr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  draw_cmd_t cmd,
  output logic      busy,
  output logic      m_axis_tvalid,
  input  logic      m_axis_tready,
  output logic [39:0] m_axis_tdata,  // pixel_x[15:0], pixel_y[31:16], pixel_colour[39:32]
  output logic      m_axis_tlast   // last_pixel
);

  scan_state_t state;
  cell_mask_t  mask;
  logic [1:0]  dx;
  coord_t      col;
  coord_t      row;
  coord_t      base_col;
  colour_t     colour;

  logic out_free;
  logic load_out;
  logic step;
  logic rest_empty;

  assign busy       = (state != ST_IDLE);
  assign out_free   = !m_axis_tvalid || m_axis_tready;
  assign rest_empty = (mask[CELL_PIXELS-1:1] == '0);
  assign load_out   = (state == ST_SCAN) && mask[0] && out_free;
  // clear bits advance freely; set bits wait for room in the output register
  assign step       = (state == ST_SCAN) && (!mask[0] || load_out);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      mask          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= {colour, row, col};
        m_axis_tlast  <= rest_empty;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (start) begin
        state    <= ST_SCAN;
        mask     <= cmd.mask;
        col      <= cmd.col;
        base_col <= cmd.col;
        row      <= cmd.row;
        colour   <= cmd.colour;
        dx       <= 2'd0;
      end else if (step) begin
        mask <= mask >> 1;
        if (rest_empty) begin
          state <= ST_IDLE;
        end
        if (dx == 2'd2) begin
          dx  <= 2'd0;
          col <= base_col;
          row <= row + 16'd1;
        end else begin
          dx  <= dx + 2'd1;
          col <= col + 16'd1;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (state == ST_IDLE))
    else $error("draw command issued while scanning");

  a_idle_mask_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (mask == '0))
    else $error("mask bits left over in idle");

  a_last_ends_scan: assert property (@(posedge clk) disable iff (rst)
    (load_out && rest_empty) |=> (state == ST_IDLE))
    else $error("scan continued past the last pixel");

  a_dx_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (dx != 2'd3))
    else $error("column offset outside the cell");
`endif

endmodule

>>> src/glyph_pixel_renderer.sv
// Top level: cursor, glyph lookup and input handshake of the glyph pixel renderer.
// Place transaction: cursor updated at the edge that accepts it, no output.
// Draw transaction: the cell mask shifts out one bit per cycle unless stalled,
// and the input stays not ready until the scan ends; each pixel passes through
// the output register before it leaves.
// Output stalls hold the scan only on set pixels. Reset clears cursor to 0,0
// and drops output valid.
module glyph_pixel_renderer
  import gpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // char_code[7:0], x[23:8], y[39:24], colour[47:40]
  input  logic        s_axis_tuser,  // func: 0 place, 1 draw
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // pixel_x[15:0], pixel_y[31:16], pixel_colour[39:32]
  output logic        m_axis_tlast   // last_pixel
);

  coord_t cursor_col;
  coord_t cursor_row;

  logic [CODE_W-1:0]      char_code;
  coord_t                 in_x;
  coord_t                 in_y;
  colour_t                in_colour;
  logic                   accept;
  logic                   in_range;
  logic [GLYPH_IDX_W-1:0] glyph_idx;
  glyph_entry_t           entry;
  cell_mask_t             mask;
  logic                   busy;
  logic                   start;
  draw_cmd_t              cmd;

  assign char_code = s_axis_tdata[7:0];
  assign in_x      = s_axis_tdata[23:8];
  assign in_y      = s_axis_tdata[39:24];
  assign in_colour = s_axis_tdata[47:40];

  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // codes 32..127 only
  assign in_range  = !char_code[7] && (char_code[6:5] != 2'b00);
  assign glyph_idx = GLYPH_IDX_W'(char_code[6:0] - 7'(FIRST_CODE));
  assign entry     = GLYPH_ROM[glyph_idx];
  assign mask      = scan_mask(entry);

  assign start      = accept && s_axis_tuser && in_range && (mask != '0);
  assign cmd.mask   = mask;
  assign cmd.col    = cursor_col;
  assign cmd.row    = cursor_row + {15'd0, entry[0]};  // descender drops the cell a row
  assign cmd.colour = in_colour;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
    end else if (accept) begin
      if (!s_axis_tuser) begin
        cursor_col <= in_x;
        cursor_row <= in_y;
      end else if (in_range) begin
        cursor_col <= cursor_col + COORD_W'(GLYPH_ADVANCE);
      end
    end
  end

  gpr_cell_scan u_scan (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .cmd           (cmd),
    .busy          (busy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

>>> bench/glyph_pixel_renderer_tb.sv
// Self-checking testbench for the glyph pixel renderer: cursor moves, glyph pixel streams.
module glyph_pixel_renderer_tb;
  import gpr_pkg::*;

  typedef enum logic {
    OP_PLACE = 1'b0,
    OP_DRAW  = 1'b1
  } op_t;

  typedef struct {
    coord_t  px;
    coord_t  py;
    colour_t colour;
    logic    is_last;
  } pixel_t;

  localparam int DESCENDER_BIT = 0;
  localparam int DRAIN_CYCLES  = 24;
  localparam int CLK_PERIOD    = 12;

  // Font table, one entry per code from 32 up.
  localparam logic [15:0] FONT [96] = '{
    16'h0000, 16'h4908, 16'hb400, 16'hbef6, 16'h7b7a, 16'ha594, 16'h55b8, 16'h4800,
    16'h2944, 16'h442a, 16'h15a0, 16'h0b42, 16'h0050, 16'h0302, 16'h0008, 16'h2590,
    16'h76ba, 16'h595c, 16'hc59e, 16'hc538, 16'h92e6, 16'hf33a, 16'h73ba, 16'he590,
    16'h77ba, 16'h773a, 16'h0840, 16'h0850, 16'h2a44, 16'h1ce0, 16'h8852, 16'he508,
    16'h568e, 16'h77b6, 16'h77b8, 16'h728c, 16'hd6ba, 16'h739e, 16'h7392, 16'h72ae,
    16'hb7b6, 16'he95c, 16'h64aa, 16'hb7b4, 16'h929c, 16'hbeb6, 16'hd6b6, 16'h56aa,
    16'hd792, 16'h76ee, 16'h77b4, 16'h7138, 16'he948, 16'hb6ae, 16'hb6aa, 16'hb6f6,
    16'hb5b4, 16'hb548, 16'he59c, 16'h694c, 16'h9124, 16'h642e, 16'h5400, 16'h001c,
    16'h4400, 16'h0eae, 16'h9aba, 16'h0e8c, 16'h2eae, 16'h0ece, 16'h56d0, 16'h553b,
    16'h93b4, 16'h4144, 16'h4151, 16'h97b4, 16'h4944, 16'h17b6, 16'h1ab6, 16'h0aaa,
    16'hd6d3, 16'h7667, 16'h1790, 16'h0f38, 16'h9a8c, 16'h16ae, 16'h16ba, 16'h16f6,
    16'h15b4, 16'hb52b, 16'h1c5e, 16'h6b4c, 16'h4948, 16'hc95a, 16'h5400, 16'h56e2
  };

  // Entry bit for each cell position, row by row, left to right.
  // Row 2 column 2 sits in bit 1, out of sequence.
  localparam int SCAN_BIT [15] = '{15, 14, 13, 12, 11, 10, 9, 8, 1, 7, 6, 5, 4, 3, 2};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // char_code[7:0], x[23:8], y[39:24], colour[47:40]
  logic        s_axis_tuser = 1'b0; // func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // pixel_x[15:0], pixel_y[31:16], pixel_colour[39:32]
  logic        m_axis_tlast;        // last_pixel

  coord_t cur_col = '0;
  coord_t cur_row = '0;
  pixel_t pending_pixels [$];
  int     bad_count = 0;
  int     pixel_count = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     hold_left = 0;

  glyph_pixel_renderer DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Expected pixel writes for one accepted transaction, plus cursor update.
  task automatic plot_glyph(op_t op, logic [7:0] code, coord_t x, coord_t y,
                            colour_t colour);
    logic [15:0] entry;
    coord_t      base_row;
    pixel_t      pix;
    int          total;
    int          n;
    if (op == OP_PLACE) begin
      cur_col = x;
      cur_row = y;
    end else if (code >= FIRST_CODE && code < FIRST_CODE + GLYPH_COUNT) begin
      entry = FONT[code - FIRST_CODE];
      base_row = cur_row + entry[DESCENDER_BIT];
      total = 0;
      for (int k = 0; k < CELL_PIXELS; k++) total += entry[SCAN_BIT[k]];
      n = 0;
      for (int k = 0; k < CELL_PIXELS; k++) begin
        if (entry[SCAN_BIT[k]]) begin
          n++;
          pix.px = cur_col + coord_t'(k % 3);
          pix.py = base_row + coord_t'(k / 3);
          pix.colour = colour;
          pix.is_last = (n == total);
          pending_pixels.push_back(pix);
        end
      end
      cur_col = cur_col + coord_t'(GLYPH_ADVANCE);
    end
  endtask

  task automatic send_item(op_t op, logic [7:0] code, coord_t x, coord_t y,
                           colour_t colour);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {colour, y, x, code};
    do @(posedge clk); while (!s_axis_tready);
    plot_glyph(op, code, x, y, colour);
  endtask

  task automatic send_random_item();
    int     pick;
    coord_t x;
    coord_t y;
    pick = $urandom_range(99);
    x = coord_t'($urandom);
    y = coord_t'($urandom);
    if (pick < 15) begin
      // sometimes park the cursor right at a wrap point
      if ($urandom_range(3) == 0) x = $urandom_range(1) ? 16'hfffd : 16'h7ffe;
      send_item(OP_PLACE, 8'($urandom), x, y, colour_t'($urandom));
    end else if (pick < 25) begin
      send_item(OP_DRAW, 8'($urandom), x, y, colour_t'($urandom));
    end else begin
      send_item(OP_DRAW, 8'($urandom_range(FIRST_CODE + GLYPH_COUNT - 1, FIRST_CODE)),
                x, y, colour_t'($urandom));
    end
  endtask

  // Sender pauses until every pixel is out, then lets the scanner settle.
  task automatic drain_pixels();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic test_directed();
    set_idling(0, 0);
    send_item(OP_DRAW, 8'd33, 16'h1234, 16'h5678, 8'h00);   // cursor straight from reset
    send_item(OP_DRAW, 8'd32, 16'h0000, 16'h0000, 8'hff);   // blank glyph still advances
    send_item(OP_DRAW, 8'd127, 16'hffff, 16'hffff, 8'hff);
    send_item(OP_DRAW, 8'd0, 16'h0000, 16'h0000, 8'h11);    // codes outside the font
    send_item(OP_DRAW, 8'd31, 16'h0000, 16'h0000, 8'h22);
    send_item(OP_DRAW, 8'd128, 16'h0000, 16'h0000, 8'h33);
    send_item(OP_DRAW, 8'd255, 16'h0000, 16'h0000, 8'h44);
    send_item(OP_DRAW, 8'd35, 16'h0000, 16'h0000, 8'h55);
    send_item(OP_PLACE, 8'hff, 16'h7ffe, 16'h7ffd, 8'hff);  // signed boundary
    send_item(OP_DRAW, 8'd35, 16'h8000, 16'h8000, 8'haa);
    send_item(OP_DRAW, 8'd103, 16'h0000, 16'h0000, 8'h5a);  // descender
    send_item(OP_PLACE, 8'h00, 16'hfffe, 16'hfffc, 8'h00);  // unsigned wrap
    send_item(OP_DRAW, 8'd106, 16'h0000, 16'h0000, 8'hc3);
    send_item(OP_DRAW, 8'd112, 16'h0000, 16'h0000, 8'h3c);
    send_item(OP_DRAW, 8'd64, 16'h0000, 16'h0000, 8'h01);
    send_item(OP_PLACE, 8'h41, 16'h8000, 16'h8000, 8'h80);
    send_item(OP_DRAW, 8'd87, 16'h7fff, 16'h7fff, 8'hfe);
    send_item(OP_PLACE, 8'h00, 16'h0000, 16'h0000, 8'h00);
    send_item(OP_DRAW, 8'd95, 16'h0000, 16'h0000, 8'h7f);
    send_item(OP_DRAW, 8'd46, 16'h0000, 16'h0000, 8'h80);
    drain_pixels();
  endtask

  task automatic test_random_traffic(int count, int send_pct, int recv_pct);
    set_idling(send_pct, recv_pct);
    repeat (count) send_random_item();
    drain_pixels();
  endtask

  // Output held off while draws keep coming, so the input must stall.
  task automatic test_output_hold();
    set_idling(0, 0);
    hold_left = 200;
    repeat (12) send_item(OP_DRAW, 8'($urandom_range(FIRST_CODE + GLYPH_COUNT - 1, 40)),
                          coord_t'($urandom), coord_t'($urandom), colour_t'($urandom));
    drain_pixels();
  endtask

  // Receiver readiness, changed on the falling edge.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
    $display("pixel %0d %s: got %h, want %h", pixel_count, field, got, want);
    bad_count++;
  endtask

  always @(posedge clk) begin
    pixel_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected write x", m_axis_tdata[15:0], 16'h0000);
      end else begin
        want = pending_pixels.pop_front();
        if (m_axis_tdata[15:0] !== want.px)
          report_mismatch("x", m_axis_tdata[15:0], want.px);
        if (m_axis_tdata[31:16] !== want.py)
          report_mismatch("y", m_axis_tdata[31:16], want.py);
        if (m_axis_tdata[39:32] !== want.colour)
          report_mismatch("colour", 16'(m_axis_tdata[39:32]), 16'(want.colour));
        if (m_axis_tlast !== want.is_last)
          report_mismatch("last", 16'(m_axis_tlast), 16'(want.is_last));
      end
      pixel_count++;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_traffic(22, 0, 0);
    test_random_traffic(22, 70, 0);
    test_random_traffic(22, 0, 70);
    test_random_traffic(22, 25, 25);
    test_output_hold();
    if (pending_pixels.size() != 0)
      report_mismatch("writes missing", 16'(pending_pixels.size()), 16'h0000);
    if (bad_count == 0)
      $display("glyph_pixel_renderer: match");
    else
      $display("glyph_pixel_renderer: mismatch");
    $finish;
  end

  initial begin
    #(CLK_PERIOD * 300000);
    $display("glyph_pixel_renderer: mismatch");
    $finish;
  end

endmodule
